FILE: rtl/lr_pkg.sv
package lr_pkg;

    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 24;
    localparam int ERR_W       = COORD_W + 3;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic signed [ERR_W-1:0] err_t;

    // One classified line, ready for the stepper
    typedef struct packed {
        logic   steep;
        logic   step_neg;
        coord_t maj;
        coord_t maj_end;
        coord_t mnr;
        coord_t dx;
        coord_t dy;
        color_t color;
    } lr_cmd_t;

    typedef struct packed {
        logic busy;
        logic loading;
    } lr_back_status_t;

endpackage

FILE: rtl/line_rasterizer.sv
// Channel   Handshake             Payload
// command   in_valid / in_ready   x_start, y_start, x_end, y_end, line_color
// pixel     out_valid / out_ready pixel_x, pixel_y, pixel_color, last_pixel
//
// The stepper loads a line from the command queue, then emits one pixel per
// cycle while the pixel output does not stall, set by the single Bresenham
// error update per cycle. Zero-length lines are dropped at setup.
// The setup stage takes one command per cycle into a two-entry queue while it
// is not full, so commands are accepted while the stepper is busy or stalls.
// Reset is asynchronous and clears queue and stepper control only.
module line_rasterizer
    import lr_pkg::*;
#(
    parameter int TILE_SIZE = 64
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  coord_t x_start,
    input  coord_t y_start,
    input  coord_t x_end,
    input  coord_t y_end,
    input  color_t line_color,
    output logic   out_valid,
    input  logic   out_ready,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output color_t pixel_color,
    output logic   last_pixel
);

    localparam coord_t TILE_MAX = COORD_W'(TILE_SIZE - 1);

    logic            q_full;
    logic            q_push;
    lr_cmd_t         q_in;
    logic            q_pop;
    lr_cmd_t         q_out;
    logic            q_valid;
    lr_back_status_t back_status;

    lr_setup #(
        .TILE_SIZE(TILE_SIZE)
    ) u_setup (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .line_color(line_color),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    lr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_out),
        .not_empty(q_valid)
    );

    lr_stepper u_stepper (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_color(pixel_color),
        .last_pixel (last_pixel),
        .status     (back_status)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("request pushed into a full queue");

    a_load_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.loading |=> back_status.busy)
        else $error("stepper not busy after loading a request");

    a_pixel_in_tile: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pixel_x <= TILE_MAX && pixel_y <= TILE_MAX))
        else $error("pixel outside tile");

    a_queued_line_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_out.dx != '0)
        else $error("zero-length line reached the stepper");

endmodule

FILE: rtl/lr_setup.sv
module lr_setup
    import lr_pkg::*;
#(
    parameter int TILE_SIZE = 64
)
(
    input  logic    in_valid,
    output logic    in_ready,
    input  coord_t  x_start,
    input  coord_t  y_start,
    input  coord_t  x_end,
    input  coord_t  y_end,
    input  color_t  line_color,
    input  logic    q_full,
    output logic    q_push,
    output lr_cmd_t q_data
);

    localparam coord_t TILE_MAX = COORD_W'(TILE_SIZE - 1);

    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t adx;
    coord_t ady;
    logic   steep;
    coord_t p0_maj;
    coord_t p0_mnr;
    coord_t p1_maj;
    coord_t p1_mnr;
    coord_t lo_maj;
    coord_t lo_mnr;
    coord_t hi_maj;
    coord_t hi_mnr;

    always_comb
    begin
        // saturate coordinates into the tile
        ax = (x_start > TILE_MAX) ? TILE_MAX : x_start;
        ay = (y_start > TILE_MAX) ? TILE_MAX : y_start;
        bx = (x_end   > TILE_MAX) ? TILE_MAX : x_end;
        by = (y_end   > TILE_MAX) ? TILE_MAX : y_end;

        adx   = (bx > ax) ? bx - ax : ax - bx;
        ady   = (by > ay) ? by - ay : ay - by;
        steep = ady > adx;

        p0_maj = steep ? ay : ax;
        p0_mnr = steep ? ax : ay;
        p1_maj = steep ? by : bx;
        p1_mnr = steep ? bx : by;

        // order endpoints so the major axis increases
        if (p0_maj > p1_maj)
        begin
            lo_maj = p1_maj;
            lo_mnr = p1_mnr;
            hi_maj = p0_maj;
            hi_mnr = p0_mnr;
        end
        else
        begin
            lo_maj = p0_maj;
            lo_mnr = p0_mnr;
            hi_maj = p1_maj;
            hi_mnr = p1_mnr;
        end

        q_data.steep    = steep;
        q_data.step_neg = !(lo_mnr < hi_mnr);
        q_data.maj      = lo_maj;
        q_data.maj_end  = hi_maj;
        q_data.mnr      = lo_mnr;
        q_data.dx       = hi_maj - lo_maj;
        q_data.dy       = (hi_mnr > lo_mnr) ? hi_mnr - lo_mnr : lo_mnr - hi_mnr;
        q_data.color    = line_color;
    end

    assign in_ready = !q_full;
    // drop zero-length lines: they yield no pixels
    assign q_push   = in_valid && !q_full && (q_data.dx != '0);

endmodule

FILE: rtl/lr_queue.sv
module lr_queue
    import lr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  lr_cmd_t push_data,
    output logic    full,
    input  logic    pop,
    output lr_cmd_t pop_data,
    output logic    not_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    lr_cmd_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = count_reg == CNT_FULL;
    assign not_empty = count_reg != '0;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/lr_stepper.sv
module lr_stepper
    import lr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  lr_cmd_t         q_data,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output coord_t          pixel_x,
    output coord_t          pixel_y,
    output color_t          pixel_color,
    output logic            last_pixel,
    output lr_back_status_t status
);

    logic    busy_reg;
    logic    steep_reg;
    logic    step_neg_reg;
    coord_t  maj_reg;
    coord_t  maj_end_reg;
    coord_t  mnr_reg;
    coord_t  dx_reg;
    coord_t  dy_reg;
    color_t  color_reg;
    err_t    err_reg;
    logic    out_valid_reg;
    coord_t  px_reg;
    coord_t  py_reg;
    color_t  pcolor_reg;
    logic    last_reg;

    logic    advance;
    logic    at_last;
    err_t    err_sub;
    err_t    err_next;
    coord_t  mnr_next;

    assign q_pop   = !busy_reg && q_valid;
    assign advance = busy_reg && (!out_valid_reg || out_ready);
    assign at_last = ({1'b0, maj_reg} + 1'b1) == {1'b0, maj_end_reg};

    always_comb
    begin
        err_sub  = err_reg - err_t'({dy_reg, 1'b0});
        err_next = err_sub;
        mnr_next = mnr_reg;
        if (err_sub < 0)
        begin
            err_next = err_sub + err_t'({dx_reg, 1'b0});
            mnr_next = step_neg_reg ? mnr_reg - 1'b1 : mnr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                busy_reg <= 1'b1;
            else if (advance && at_last)
                busy_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            steep_reg    <= q_data.steep;
            step_neg_reg <= q_data.step_neg;
            maj_reg      <= q_data.maj;
            maj_end_reg  <= q_data.maj_end;
            mnr_reg      <= q_data.mnr;
            dx_reg       <= q_data.dx;
            dy_reg       <= q_data.dy;
            color_reg    <= q_data.color;
            err_reg      <= err_t'(q_data.dx);
        end
        else if (advance)
        begin
            maj_reg <= maj_reg + 1'b1;
            mnr_reg <= mnr_next;
            err_reg <= err_next;
        end

        if (advance)
        begin
            px_reg     <= steep_reg ? mnr_reg : maj_reg;
            py_reg     <= steep_reg ? maj_reg : mnr_reg;
            pcolor_reg <= color_reg;
            last_reg   <= at_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pixel_x        = px_reg;
    assign pixel_y        = py_reg;
    assign pixel_color    = pcolor_reg;
    assign last_pixel     = last_reg;
    assign status.busy    = busy_reg;
    assign status.loading = q_pop;

endmodule

FILE: tb/line_rasterizer_test.sv
module line_rasterizer_test;
    import lr_pkg::*;

    localparam int TILE_SIZE  = 64;
    localparam int QUIET_MAX  = 3000;
    localparam int DRAIN_TAIL = 70;
    localparam int PHASE_LEN  = 84;

    typedef struct {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t pending_pixels[$];
        int     errors;

        function int clamp_coord(coord_t v);
            return (int'(v) > TILE_SIZE - 1) ? TILE_SIZE - 1 : int'(v);
        endfunction

        // Walk the Bresenham run of one accepted request and queue its pixels.
        function void trace_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye, color_t c);
            int     ax;
            int     ay;
            int     bx;
            int     by;
            int     t;
            int     dx;
            int     dy;
            int     err;
            int     stp;
            int     mnr;
            bit     steep;
            pixel_t p;
            ax = clamp_coord(xs);
            ay = clamp_coord(ys);
            bx = clamp_coord(xe);
            by = clamp_coord(ye);
            steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
            if (steep)
            begin
                t = ax; ax = ay; ay = t;
                t = bx; bx = by; by = t;
            end
            if (ax > bx)
            begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx  = bx - ax;
            dy  = (by > ay) ? by - ay : ay - by;
            stp = (ay < by) ? 1 : -1;
            err = dx;
            mnr = ay;
            for (int maj = ax; maj < bx; maj++)
            begin
                p.x     = coord_t'(steep ? mnr : maj);
                p.y     = coord_t'(steep ? maj : mnr);
                p.color = c;
                p.last  = (maj == bx - 1);
                pending_pixels.push_back(p);
                err -= 2 * dy;
                if (err < 0)
                begin
                    mnr += stp;
                    err += 2 * dx;
                end
            end
        endfunction

        function void check_pixel(coord_t x, coord_t y, color_t c, logic last);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                         $time, x, y, c, last);
                return;
            end
            want = pending_pixels.pop_front();
            if (x !== want.x)
            begin
                errors++;
                $display("%0t: pixel_x expected %0d, got %0d", $time, want.x, x);
            end
            if (y !== want.y)
            begin
                errors++;
                $display("%0t: pixel_y expected %0d, got %0d", $time, want.y, y);
            end
            if (c !== want.color)
            begin
                errors++;
                $display("%0t: pixel_color expected %06h, got %06h", $time, want.color, c);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: last_pixel expected %0b, got %0b", $time, want.last, last);
            end
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   in_valid   = 1'b0;
    logic   in_ready;
    coord_t x_start    = '0;
    coord_t y_start    = '0;
    coord_t x_end      = '0;
    coord_t y_end      = '0;
    color_t line_color = '0;
    logic   out_valid;
    logic   out_ready  = 1'b0;
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic   last_pixel;

    pixel_scoreboard board;
    int              send_idle_pct = 26;
    int              recv_idle_pct = 79;
    int              quiet_cycles  = 0;

    line_rasterizer #(.TILE_SIZE(TILE_SIZE)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .line_color  (line_color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Note requests, check pixels, and stop a run that has gone quiet.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                board.trace_line(x_start, y_start, x_end, y_end, line_color);
            if (out_valid && out_ready)
                board.check_pixel(pixel_x, pixel_y, pixel_color, last_pixel);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_MAX);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_line(input coord_t xs, input coord_t ys, input coord_t xe,
                             input coord_t ye, input color_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        x_start    <= xs;
        y_start    <= ys;
        x_end      <= xe;
        y_end      <= ye;
        line_color <= c;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_random_line();
        int kind;
        int xs;
        int ys;
        int xe;
        int ye;
        int len;
        int t;
        kind = $urandom_range(99);
        xs   = $urandom_range(63);
        ys   = $urandom_range(63);
        xe   = $urandom_range(63);
        ye   = $urandom_range(63);
        if (kind < 20)
        begin
            // short lines around the start point
            xe = xs + int'($urandom_range(6)) - 3;
            ye = ys + int'($urandom_range(6)) - 3;
            xe = (xe < 0) ? 0 : (xe > 63) ? 63 : xe;
            ye = (ye < 0) ? 0 : (ye > 63) ? 63 : ye;
        end
        else if (kind < 28)
        begin
            xe = xs;
            ye = ys;
        end
        else if (kind < 40)
        begin
            // diagonal, horizontal or vertical
            len = $urandom_range(63);
            xs  = $urandom_range(63 - len);
            ys  = $urandom_range(63 - len);
            xe  = xs + len;
            ye  = ys + len;
            if ($urandom_range(1))
            begin
                t = xs; xs = xe; xe = t;
            end
            if ($urandom_range(1))
            begin
                t = ys; ys = ye; ye = t;
            end
            case ($urandom_range(2))
                0: ye = ys;
                1: xe = xs;
                default: ;
            endcase
        end
        else if (kind < 46)
        begin
            xs = $urandom_range(1) * 63;
            ys = $urandom_range(1) * 63;
            xe = $urandom_range(1) * 63;
            ye = $urandom_range(1) * 63;
        end
        send_line(coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye),
                  color_t'($urandom()));
    endtask

    // Hold off new requests until every queued pixel has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_line(6'd5,  6'd5,  6'd5,  6'd5,  24'h000000);
        send_line(6'd0,  6'd0,  6'd63, 6'd0,  24'hFFFFFF);
        send_line(6'd63, 6'd10, 6'd0,  6'd10, 24'h123456);
        send_line(6'd20, 6'd0,  6'd20, 6'd63, 24'hABCDEF);
        send_line(6'd40, 6'd63, 6'd40, 6'd0,  24'h555555);
        send_line(6'd0,  6'd0,  6'd63, 6'd63, 24'hAAAAAA);
        send_line(6'd63, 6'd63, 6'd0,  6'd0,  24'hFF0000);
        send_line(6'd0,  6'd63, 6'd63, 6'd0,  24'h00FF00);
        send_line(6'd63, 6'd0,  6'd0,  6'd63, 24'h0000FF);
        send_line(6'd0,  6'd0,  6'd1,  6'd0,  24'h800001);
        send_line(6'd0,  6'd0,  6'd0,  6'd1,  24'h7FFFFE);
        send_line(6'd1,  6'd1,  6'd0,  6'd0,  24'h0F0F0F);
        send_line(6'd3,  6'd7,  6'd50, 6'd20, 24'hF0F0F0);
        send_line(6'd50, 6'd20, 6'd3,  6'd7,  24'h3C3C3C);
        send_line(6'd3,  6'd20, 6'd50, 6'd7,  24'hC3C3C3);
        send_line(6'd10, 6'd2,  6'd25, 6'd60, 24'h010203);
        send_line(6'd25, 6'd60, 6'd10, 6'd2,  24'hFEDCBA);
        send_line(6'd30, 6'd5,  6'd12, 6'd58, 24'h999999);
        send_line(6'd0,  6'd0,  6'd62, 6'd63, 24'h666666);
        send_line(6'd0,  6'd0,  6'd63, 6'd62, 24'h102030);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 24'hFFFFFF);
        send_line(6'd0,  6'd0,  6'd0,  6'd0,  24'h000000);
        send_line(6'd32, 6'd32, 6'd33, 6'd31, 24'h400000);
        send_line(6'd21, 6'd42, 6'd42, 6'd21, 24'h000040);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 79 : 0;
            recv_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 26 : 0;
            repeat (PHASE_LEN) send_random_line();
            wait_drained();
        end

        repeat (DRAIN_TAIL) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
